// ===== rtl/positional_list_engine_assert.svh =====
// Assertion macros used by the list engine module.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

    // Widest index or count over the supported capacity range (up to 64 entries).
    localparam int LIST_IDX_W = 7;

    localparam logic [2:0] FN_INS_FRONT = 3'd0;
    localparam logic [2:0] FN_INS_END   = 3'd1;
    localparam logic [2:0] FN_INS_POS   = 3'd2;
    localparam logic [2:0] FN_DEL_FRONT = 3'd3;
    localparam logic [2:0] FN_DEL_END   = 3'd4;
    localparam logic [2:0] FN_DEL_POS   = 3'd5;
    localparam logic [2:0] FN_READ_ALL  = 3'd6;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_APPENDED = 3'd2;
    localparam logic [2:0] STAT_PAST_END = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;
    localparam logic [2:0] STAT_BAD_POS  = 3'd5;

    typedef enum logic [1:0] {
        CM_HOLD = 2'd0,
        CM_INS  = 2'd1,
        CM_DEL  = 2'd2,
        CM_ROT  = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t              mode;
        logic [LIST_IDX_W-1:0]   idx;
        logic [LIST_IDX_W-1:0]   last_idx;
        logic signed [31:0]      item_value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
`default_nettype none

module ple_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                      clk,
    input  ple_pkg::cell_ctrl_t       ctrl,
    input  logic signed [31:0]        left_value,
    input  logic signed [31:0]        right_value,
    input  logic signed [31:0]        head_value,
    output logic signed [31:0]        entry
);
    import ple_pkg::*;

    localparam logic [LIST_IDX_W-1:0] MY_IDX = LIST_IDX_W'(INDEX);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.mode)
            CM_INS:
            begin
                if (MY_IDX > ctrl.idx)
                begin
                    entry_next = left_value;
                end
                else if (MY_IDX == ctrl.idx)
                begin
                    entry_next = ctrl.item_value;
                end
            end
            CM_DEL:
            begin
                if (MY_IDX >= ctrl.idx)
                begin
                    entry_next = right_value;
                end
            end
            CM_ROT:
            begin
                // The last live entry wraps around to take the head.
                if (MY_IDX == ctrl.last_idx)
                begin
                    entry_next = head_value;
                end
                else if (MY_IDX < ctrl.last_idx)
                begin
                    entry_next = right_value;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Channel  Handshake             Word
// in       in_valid / in_ready   func, item_value, position
// out      out_valid / out_ready status, list_count, out_value, out_position, last_of_run
//
// Inserts, deletes and status-only operations give one word each.
// A read-out enters the read state, takes no input until its last word, and gives one word
// per entry; the chain of cells rotates one place per word, so the list ends back in order.
// rst_n clears the count, the control state and the output valid; entries are not cleared.
// A stalled output holds its word; no new input is taken until the word slot frees.
`default_nettype none
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] item_value,
    input  logic [7:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [5:0]         list_count,
    output logic signed [31:0] out_value,
    output logic [4:0]         out_position,
    output logic               last_of_run
);
    import ple_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W  = ((CW > 8) ? CW : 8) + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic              out_valid_reg, out_valid_next;

    logic [2:0]         status_reg, status_next;
    logic [5:0]         list_count_reg, list_count_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic [4:0]         out_position_reg, out_position_next;
    logic               last_reg, last_next;

    logic               load_out;
    logic               slot_free;
    logic               accept;
    logic               count_full;
    logic               count_empty;
    logic [CW-1:0]      count_m1;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    cell_ctrl_t         ctrl;

    logic signed [31:0] cell_value [CAPACITY];

    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE) && slot_free;
    assign accept      = in_valid && in_ready;
    assign count_full  = (count_reg == CW'(CAPACITY));
    assign count_empty = (count_reg == '0);
    assign count_m1    = count_reg - 1'b1;
    assign pos_ext     = CMP_W'(position);
    assign cnt_ext     = CMP_W'(count_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rd_cnt_next       = rd_cnt_reg;
        load_out          = 1'b0;
        status_next       = STAT_OK;
        out_value_next    = '0;
        out_position_next = '0;
        last_next         = 1'b1;
        ctrl.mode         = CM_HOLD;
        ctrl.idx          = '0;
        ctrl.last_idx     = LIST_IDX_W'(count_m1);
        ctrl.item_value   = item_value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (func)
                        FN_INS_FRONT, FN_INS_END, FN_INS_POS:
                        begin
                            if (count_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.mode  = CM_INS;
                                count_next = count_reg + 1'b1;
                                if (func == FN_INS_FRONT)
                                begin
                                    ctrl.idx = '0;
                                end
                                else if (func == FN_INS_END)
                                begin
                                    ctrl.idx = LIST_IDX_W'(count_reg);
                                end
                                else if (pos_ext <= CMP_W'(1))
                                begin
                                    ctrl.idx = '0;
                                end
                                else if (pos_ext <= cnt_ext + 1'b1)
                                begin
                                    ctrl.idx = LIST_IDX_W'(pos_ext - 1'b1);
                                end
                                else
                                begin
                                    ctrl.idx    = LIST_IDX_W'(count_reg);
                                    status_next = STAT_APPENDED;
                                end
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_END:
                        begin
                            if (count_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.mode  = CM_DEL;
                                count_next = count_m1;
                                ctrl.idx   = (func == FN_DEL_FRONT) ? '0
                                                                    : LIST_IDX_W'(count_m1);
                            end
                        end
                        FN_DEL_POS:
                        begin
                            if (count_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (pos_ext == '0)
                            begin
                                status_next = STAT_BAD_POS;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                status_next = STAT_PAST_END;
                            end
                            else
                            begin
                                ctrl.mode  = CM_DEL;
                                count_next = count_m1;
                                ctrl.idx   = LIST_IDX_W'(pos_ext - 1'b1);
                            end
                        end
                        FN_READ_ALL:
                        begin
                            // An empty list still answers with one word.
                            if (!count_empty)
                            begin
                                load_out    = 1'b0;
                                state_next  = S_READ;
                                rd_cnt_next = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    load_out          = 1'b1;
                    ctrl.mode         = CM_ROT;
                    out_value_next    = cell_value[0];
                    out_position_next = 5'(rd_cnt_reg);
                    last_next         = (CW'(rd_cnt_reg) == count_m1);
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        list_count_next = 6'(count_next);
        out_valid_next  = (out_valid_reg && !out_ready) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg       <= status_next;
            list_count_reg   <= list_count_next;
            out_value_reg    <= out_value_next;
            out_position_reg <= out_position_next;
            last_reg         <= last_next;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;

        if (g == 0)
        begin : g_first
            assign left_value = cell_value[0];
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_final
            assign right_value = cell_value[g];
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[g+1];
        end

        ple_cell #(
            .INDEX(g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_value (left_value),
            .right_value(right_value),
            .head_value (cell_value[0]),
            .entry      (cell_value[g])
        );
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign list_count   = list_count_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_position_reg;
    assign last_of_run  = last_reg;

    `PLE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `PLE_ASSERT_NOW(a_read_blocks_in, clk, rst_n, state_reg == S_READ, !in_ready, "input taken during read-out")
    `PLE_ASSERT_NOW(a_read_index, clk, rst_n, state_reg == S_READ, CW'(rd_cnt_reg) < count_reg, "read index past count")
    `PLE_ASSERT_NEXT(a_count_steady, clk, rst_n, !accept, $stable(count_reg), "count moved without an input word")

endmodule

`default_nettype wire

// ===== tb/positional_list_engine_tb.sv =====
module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int unsigned CAPACITY = 32;
    localparam int RANDOM_OPS = 480;
    localparam int LONG_HOLD = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    // Code 7 has no operation behind it; the block still answers with one word.
    localparam logic [2:0] FN_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         list_count;
        logic signed [31:0] value;
        logic [4:0]         slot;
        logic               last_flag;
    } list_word_t;

    class list_scoreboard;
        int unsigned capacity;
        logic signed [31:0] list_image[$];
        list_word_t pending_words[$];
        int errors;

        function new(int unsigned cap);
            capacity = cap;
            errors = 0;
        endfunction

        function int list_size();
            return list_image.size();
        endfunction

        function int pending_count();
            return pending_words.size();
        endfunction

        function void expect_word(logic [2:0] st, logic signed [31:0] v, int idx, bit last_flag);
            list_word_t w;
            w.status = st;
            w.list_count = 6'(list_image.size());
            w.value = v;
            w.slot = 5'(idx);
            w.last_flag = last_flag;
            pending_words.push_back(w);
        endfunction

        // Applies one accepted operation to the list image and queues its words.
        function void note_op(logic [2:0] op, logic signed [31:0] v, logic [7:0] p);
            logic [2:0] st;
            int n;
            st = STAT_OK;
            n = list_image.size();
            case (op)
                FN_INS_FRONT, FN_INS_END, FN_INS_POS:
                begin
                    if (n >= capacity)
                        st = STAT_FULL;
                    else if (op == FN_INS_FRONT)
                        list_image.push_front(v);
                    else if (op == FN_INS_END)
                        list_image.push_back(v);
                    else if (p <= 1)
                        list_image.push_front(v);
                    else if (int'(p) <= n + 1)
                        list_image.insert(int'(p) - 1, v);
                    else
                    begin
                        list_image.push_back(v);
                        st = STAT_APPENDED;
                    end
                end
                FN_DEL_FRONT, FN_DEL_END:
                begin
                    if (n == 0)
                        st = STAT_EMPTY;
                    else if (op == FN_DEL_FRONT)
                        void'(list_image.pop_front());
                    else
                        void'(list_image.pop_back());
                end
                FN_DEL_POS:
                begin
                    if (n == 0)
                        st = STAT_EMPTY;
                    else if (p == 0)
                        st = STAT_BAD_POS;
                    else if (int'(p) > n)
                        st = STAT_PAST_END;
                    else
                        list_image.delete(int'(p) - 1);
                end
                FN_READ_ALL:
                begin
                    if (n == 0)
                        expect_word(STAT_OK, 0, 0, 1'b1);
                    for (int i = 0; i < n; i++)
                        expect_word(STAT_OK, list_image[i], i, i == n - 1);
                    return;
                end
                default: ;
            endcase
            expect_word(st, 0, 0, 1'b1);
        endfunction

        function void check_word(list_word_t got);
            list_word_t want;
            if (pending_words.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected output word: status=%0d count=%0d value=%0d slot=%0d last=%0d",
                             got.status, got.list_count, got.value, got.slot, got.last_flag);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got.status !== want.status || got.list_count !== want.list_count ||
                got.value !== want.value || got.slot !== want.slot ||
                got.last_flag !== want.last_flag)
            begin
                if (errors < 10)
                    $display("word mismatch: expected status=%0d count=%0d value=%0d slot=%0d last=%0d, got status=%0d count=%0d value=%0d slot=%0d last=%0d",
                             want.status, want.list_count, want.value, want.slot, want.last_flag,
                             got.status, got.list_count, got.value, got.slot, got.last_flag);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] func = FN_INS_FRONT;
    logic signed [31:0] item_value = '0;
    logic [7:0] position = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [5:0] list_count;
    logic signed [31:0] out_value;
    logic [4:0] out_position;
    logic last_of_run;

    list_scoreboard sb;
    bit hold_output = 1'b0;
    int send_burst = 0;
    int recv_burst = 0;

    positional_list_engine #(.CAPACITY(CAPACITY)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly random gaps, with occasional runs of back-to-back words.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(10, 30);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [2:0] op, input logic signed [31:0] v,
                             input logic [7:0] p);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        item_value <= v;
        position <= p;
        do @(posedge clk); while (!in_ready);
        sb.note_op(op, v, p);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_count() != 0);
    endtask

    initial
    begin
        list_word_t got;
        int gap;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                // Long stall so the block backs up and stops taking input.
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = draw_gap(recv_burst);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = '{status, list_count, out_value, out_position, last_of_run};
            sb.check_word(got);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [2:0] ins_ops[3];
        logic [2:0] del_ops[3];
        logic [2:0] op;
        logic [7:0] p;
        bit filling;
        bit insert_now;
        int n;
        int r;

        ins_ops = '{FN_INS_FRONT, FN_INS_END, FN_INS_POS};
        del_ops = '{FN_DEL_FRONT, FN_DEL_END, FN_DEL_POS};
        sb = new(CAPACITY);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list: read-out and every kind of delete.
        send_word(FN_READ_ALL, 0, 0);
        send_word(FN_DEL_FRONT, 0, 0);
        send_word(FN_DEL_END, 0, 0);
        send_word(FN_DEL_POS, 0, 8'd3);
        send_word(FN_DEL_POS, 0, 8'd0);
        // Inserts at each place, including both front aliases and appends.
        send_word(FN_INS_FRONT, 32'sh7FFF_FFFF, 8'd0);
        send_word(FN_INS_END, 32'sh8000_0000, 8'd255);
        send_word(FN_INS_POS, -1, 8'd0);
        send_word(FN_INS_POS, 0, 8'd1);
        send_word(FN_INS_POS, 1, 8'd5);
        send_word(FN_INS_POS, 32'sh5555_5555, 8'd255);
        send_word(FN_INS_POS, 32'shAAAA_AAAA, 8'd7);
        send_word(FN_INS_POS, 12345, 8'd3);
        send_word(FN_READ_ALL, 0, 0);
        send_word(FN_DEL_POS, 0, 8'd0);
        send_word(FN_DEL_POS, 0, 8'd255);
        send_word(FN_DEL_POS, 0, 8'd9);
        send_word(FN_DEL_POS, 0, 8'd8);
        send_word(FN_DEL_POS, 0, 8'd2);
        send_word(FN_DEL_FRONT, 0, 0);
        send_word(FN_DEL_END, 0, 0);
        send_word(FN_UNUSED, 32'sh1234_5678, 8'd4);
        send_word(FN_READ_ALL, 0, 0);

        // Alternate fill and drain phases so the list hits both full and empty.
        filling = 1'b1;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i == RANDOM_OPS / 3)
                hold_output = 1'b1;
            if (i == 2 * RANDOM_OPS / 3)
                wait_drained();
            n = sb.list_size();
            if (filling && n == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && n == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            r = $urandom_range(0, 19);
            insert_now = filling ? (r < 16) : (r >= 16);
            if (r < 2)
                op = FN_READ_ALL;
            else if (insert_now)
                op = ins_ops[$urandom_range(0, 2)];
            else
                op = del_ops[$urandom_range(0, 2)];
            if ($urandom_range(0, 3) == 0)
                p = 8'($urandom_range(0, 255));
            else
                p = 8'($urandom_range(0, n + 2));
            send_word(op, pick_value(), p);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
